### src/velocity_autocorrelation_assert.svh
// Assertion macros for the velocity autocorrelation block.
// Expects signals named clk and rst_n in the scope where a macro is used.
`ifndef VELOCITY_AUTOCORRELATION_ASSERT_SVH
`define VELOCITY_AUTOCORRELATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/vac_pkg.sv
// Shared types and constants for the velocity autocorrelation block.
// No dependencies; vac_if, the top module, vac_mac and vac_div use this package.
`timescale 1ns / 1ps
`default_nettype none

package vac_pkg;

  // Parameter defaults
  localparam int MAX_ATOMS_DEF = 1024;
  localparam int VEL_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int CNT_W   = 11;
  localparam int CORR_W  = 33;
  localparam int FRAME_W = 16;

  // Saturation limits of the mean and the frame counter
  localparam logic [CORR_W-1:0]  CORR_MAX  = 33'h0_FFFF_FFFF;
  localparam logic [CORR_W-1:0]  CORR_MIN  = 33'h1_0000_0000;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 16'hFFFF;

  // Sequencer states
  typedef enum logic [2:0] {
    VAC_IDLE,
    VAC_MUL,
    VAC_ACC,
    VAC_LDIV,
    VAC_DIV,
    VAC_FIN
  } vac_state_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic mul_en;
    logic add_en;
  } vac_mac_ctrl_t;

endpackage

`default_nettype wire

### src/vac_if.sv
// Valid/ready channel interfaces: velocity requests in, correlation results out.
// Depends on vac_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none

interface vac_in_if #(
  parameter int VEL_WIDTH = vac_pkg::VEL_WIDTH_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [VEL_WIDTH-1:0] vel_x;
  logic signed [VEL_WIDTH-1:0] vel_y;
  logic signed [VEL_WIDTH-1:0] vel_z;
  logic                        run_start;

  modport source (output valid, vel_x, vel_y, vel_z, run_start, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, run_start, output ready);
endinterface

interface vac_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vac_pkg::CORR_W-1:0] corr_value;
  logic [vac_pkg::FRAME_W-1:0]       frame_number;

  modport source (output valid, corr_value, frame_number, input ready);
  modport sink   (input valid, corr_value, frame_number, output ready);
endinterface

`default_nettype wire

### src/velocity_autocorrelation.sv
// Velocity autocorrelation. One atom velocity per request; the first frame of a
// run (after reset or a run_start request) is stored as the reference and each
// atom's dot product with its reference entry is summed through one shared
// multiplier. An ordinary request goes through the accept, three passes through
// the multiplier (x, y, z) and the final add. The frame's last atom adds the
// bit-serial divide by the atom count, one quotient bit per cycle, plus any wait
// for the result slot to drain. The block is not ready while a request is in
// work. The result register decouples the output, so the next request is taken
// while a result waits. atom_count of zero acts as one and values above
// MAX_ATOMS act as MAX_ATOMS; reference entries beyond the reference frame's
// length are not valid.
`timescale 1ns / 1ps
`default_nettype none
`include "velocity_autocorrelation_assert.svh"

module velocity_autocorrelation #(
  parameter int MAX_ATOMS = vac_pkg::MAX_ATOMS_DEF,
  parameter int VEL_WIDTH = vac_pkg::VEL_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [vac_pkg::CNT_W-1:0] cfg_wdata,
  vac_in_if.sink                    in_if,
  vac_out_if.source                 out_if
);
  import vac_pkg::*;

  localparam int IDX_W     = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int ACC_W_RAW = 2 * VEL_WIDTH + IDX_W + 1;
  localparam int ACC_W     = (ACC_W_RAW > 64) ? 64 : ACC_W_RAW;
  localparam int CMP_W     = (CNT_W > IDX_W + 1) ? CNT_W : IDX_W + 1;
  localparam int VW3       = 3 * VEL_WIDTH;

  vac_state_t               state_r, state_nxt;
  logic [1:0]               k_r, k_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt, idx_eff;
  logic [FRAME_W-1:0]       frame_r, frame_nxt;
  logic                     capt_r, capt_nxt;
  logic [CNT_W-1:0]         atom_count_r;
  logic [VW3-1:0]           vel_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CORR_W-1:0] corr_r;
  logic [FRAME_W-1:0]       fnum_r;
  logic                     load_out;
  logic                     accept;
  logic [CMP_W-1:0]         cnt_ext, n_eff;
  logic                     frame_end;
  logic                     ram_we;
  logic [VW3-1:0]           ram_q, ref_word;
  logic signed [VEL_WIDTH-1:0] op_a, op_b;
  vac_mac_ctrl_t            mac_ctrl;
  logic signed [ACC_W-1:0]  acc;
  logic                     div_start, div_done;
  logic signed [CORR_W-1:0] div_q;

  assign accept  = in_if.valid && in_if.ready;
  assign idx_eff = in_if.run_start ? '0 : idx_r;
  assign ram_we  = accept && (in_if.run_start || capt_r);

  // Effective atom count: zero acts as one, clamp at the store depth
  always_comb begin
    cnt_ext = CMP_W'(atom_count_r);
    if (cnt_ext == '0) begin
      n_eff = CMP_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_ATOMS)) begin
      n_eff = CMP_W'(MAX_ATOMS);
    end else begin
      n_eff = cnt_ext;
    end
  end

  assign frame_end = (CMP_W'(idx_r) + CMP_W'(1)) >= n_eff;

  // Reference store, one entry of three components per atom
  vac_ram #(
    .WIDTH (VW3),
    .DEPTH (MAX_ATOMS),
    .AW    (IDX_W)
  ) u_ref_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_eff),
    .wdata ({in_if.vel_x, in_if.vel_y, in_if.vel_z}),
    .re    (accept),
    .raddr (idx_eff),
    .rdata (ram_q)
  );

  // Pick the component for this multiplier pass; the reference frame is its own
  assign ref_word = capt_r ? vel_r : ram_q;
  always_comb begin
    case (k_r)
      2'd0: begin
        op_a = $signed(vel_r[VW3-1:2*VEL_WIDTH]);
        op_b = $signed(ref_word[VW3-1:2*VEL_WIDTH]);
      end
      2'd1: begin
        op_a = $signed(vel_r[2*VEL_WIDTH-1:VEL_WIDTH]);
        op_b = $signed(ref_word[2*VEL_WIDTH-1:VEL_WIDTH]);
      end
      default: begin
        op_a = $signed(vel_r[VEL_WIDTH-1:0]);
        op_b = $signed(ref_word[VEL_WIDTH-1:0]);
      end
    endcase
  end

  vac_mac #(
    .VEL_WIDTH (VEL_WIDTH),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .op_a  (op_a),
    .op_b  (op_b),
    .acc   (acc)
  );

  vac_div #(
    .ACC_W (ACC_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc),
    .divisor  (n_eff[CNT_W-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Sequencer: next state and unit controls
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    frame_nxt     = frame_r;
    capt_nxt      = capt_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    div_start     = 1'b0;
    mac_ctrl      = '0;
    in_if.ready   = 1'b0;
    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      VAC_IDLE: begin
        in_if.ready = 1'b1;
        if (accept) begin
          idx_nxt   = idx_eff;
          k_nxt     = 2'd0;
          state_nxt = VAC_MUL;
          if (in_if.run_start) begin
            frame_nxt      = '0;
            capt_nxt       = 1'b1;
            mac_ctrl.clear = 1'b1;
          end
        end
      end
      VAC_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.add_en = (k_r != 2'd0);
        k_nxt           = k_r + 2'd1;
        if (k_r == 2'd2) begin
          state_nxt = VAC_ACC;
        end
      end
      VAC_ACC: begin
        mac_ctrl.add_en = 1'b1;
        if (frame_end) begin
          idx_nxt   = '0;
          state_nxt = VAC_LDIV;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = VAC_IDLE;
        end
      end
      VAC_LDIV: begin
        div_start      = 1'b1;
        mac_ctrl.clear = 1'b1;
        state_nxt      = VAC_DIV;
      end
      VAC_DIV: begin
        if (div_done) begin
          state_nxt = VAC_FIN;
        end
      end
      VAC_FIN: begin
        // Hold until the result slot is free
        if (!out_valid_r || out_if.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          capt_nxt      = 1'b0;
          if (frame_r != FRAME_MAX) begin
            frame_nxt = frame_r + FRAME_W'(1);
          end
          state_nxt = VAC_IDLE;
        end
      end
      default: begin
        state_nxt = VAC_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= VAC_IDLE;
      k_r          <= 2'd0;
      idx_r        <= '0;
      frame_r      <= '0;
      capt_r       <= 1'b1;
      out_valid_r  <= 1'b0;
      atom_count_r <= CNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      frame_r     <= frame_nxt;
      capt_r      <= capt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        atom_count_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      vel_r <= {in_if.vel_x, in_if.vel_y, in_if.vel_z};
    end
    if (load_out) begin
      corr_r <= div_q;
      fnum_r <= frame_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.corr_value   = corr_r;
  assign out_if.frame_number = fnum_r;

  `VAC_ASSERT_NEXT(a_accept_mul, accept, state_r == VAC_MUL && k_r == 2'd0,
    "accepted request did not start the multiply passes")
  `VAC_ASSERT_NEXT(a_div_fin, state_r == VAC_DIV && div_done, state_r == VAC_FIN,
    "divider result was not taken")
  `VAC_ASSERT_NOW(a_ref_frame, state_r == VAC_IDLE && !capt_r, frame_r != '0,
    "reference capture ended without a frame count")
  `VAC_ASSERT_NOW(a_out_src, out_valid_r && !$past(out_valid_r), $past(state_r) == VAC_FIN,
    "result raised outside the finish step")

endmodule

`default_nettype wire

### src/vac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module vac_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### src/vac_mac.sv
// Shared multiply-accumulate unit: one signed multiplier, a product register
// and the frame accumulator. Depends on vac_pkg for the control struct.
`timescale 1ns / 1ps
`default_nettype none

module vac_mac #(
  parameter int VEL_WIDTH = 16,
  parameter int ACC_W     = 43
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vac_pkg::vac_mac_ctrl_t      ctrl,
  input  logic signed [VEL_WIDTH-1:0] op_a,
  input  logic signed [VEL_WIDTH-1:0] op_b,
  output logic signed [ACC_W-1:0]     acc
);
  import vac_pkg::*;

  logic signed [2*VEL_WIDTH-1:0] product_r;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;

  // Register the product before it reaches the adder
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      product_r <= op_a * op_b;
    end
  end

  // Clear or add the held product; the sum wraps at the accumulator width
  always_comb begin
    acc_nxt = acc_r;
    if (ctrl.clear) begin
      acc_nxt = '0;
    end else if (ctrl.add_en) begin
      acc_nxt = acc_r + ACC_W'(product_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

### src/vac_div.sv
// Bit-serial restoring divider: signed sum over the atom count, truncated
// toward zero and saturated to the result width. Depends on vac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vac_div #(
  parameter int ACC_W = 43
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ACC_W-1:0]           dividend,
  input  logic [vac_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output logic signed [vac_pkg::CORR_W-1:0] quotient
);
  import vac_pkg::*;

  localparam int CW   = $clog2(ACC_W + 1);
  localparam int QX_W = (ACC_W > 34) ? ACC_W : 34;
  localparam logic [QX_W-1:0] LIM_POS = QX_W'(64'h0_FFFF_FFFF);
  localparam logic [QX_W-1:0] LIM_NEG = QX_W'(64'h1_0000_0000);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0] quo_r, quo_nxt;
  logic [CNT_W:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0] dvs_r, dvs_nxt;
  logic             neg_r, neg_nxt;
  logic [CNT_W:0]   rem_sh;
  logic             ge;
  logic [QX_W-1:0]  q_ext;

  // One quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    rem_sh   = {rem_r[CNT_W-1:0], quo_r[ACC_W-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend[ACC_W-1];
      quo_nxt  = dividend[ACC_W-1] ? (ACC_W'(0) - dividend) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[ACC_W-2:0], ge};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(ACC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // Apply the sign and saturate
  always_comb begin
    q_ext = QX_W'(quo_r);
    if (neg_r) begin
      quotient = (q_ext > LIM_NEG) ? CORR_MIN : (CORR_W'(0) - q_ext[CORR_W-1:0]);
    end else begin
      quotient = (q_ext > LIM_POS) ? CORR_MAX : q_ext[CORR_W-1:0];
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire
